@@ rtl/core/tti_pkg.sv @@
// Shared constants and types for the thermistor table interpolator.
// Depends on nothing; the top level refers to it by scoped names.
package tti_pkg;

  // Default sizes of the table and the converter.
  localparam int unsigned TABLE_ENTRIES_DEF = 32;
  localparam int unsigned SAMPLE_BITS_DEF   = 12;
  localparam int unsigned TABLE_BITS_DEF    = 12;

  // Fixed field widths.
  localparam int unsigned OP_W       = 1;
  localparam int unsigned INDEX_W    = 5;
  localparam int unsigned ENTRY_W    = 16;
  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned TEMP_Q8_W  = 24;
  localparam int unsigned SEG_W      = 6;
  localparam int unsigned FRAC_BITS  = 8;

  // Datapath widths: aligned sample, product, scaled numerator, final sum.
  localparam int unsigned ALIGN_W = 16;
  localparam int unsigned DS_W    = 18;
  localparam int unsigned DT_W    = 17;
  localparam int unsigned PROD_W  = DS_W + DT_W;
  localparam int unsigned NUM_W   = PROD_W + FRAC_BITS;
  localparam int unsigned SUM_W   = NUM_W + 1;
  localparam int unsigned STEP_W  = $clog2(NUM_W);

  localparam int Q8_MAX = 8388607;
  localparam int Q8_MIN = -8388608;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_LOAD    = 1'b0;
  localparam logic [OP_W-1:0] OP_CONVERT = 1'b1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SCAN = 7'b0000010,
    S_MUL  = 7'b0000100,
    S_PREP = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_SUM  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

endpackage

@@ rtl/core/thermistor_table_interpolator.sv @@
// Thermistor table interpolator: table memory, scan sequencer and divider.
// Uses tti_pkg for widths, operation codes and the state type.
// A load beat with an in-range index is written into the table memory on acceptance. A convert
// beat scans up to the first raw value above the sample, then goes through multiply, prepare,
// the divider steps, sum and output; a flat segment skips the divider, and a sample beyond the
// table goes from the scan straight to the sum. An unaccepted result holds the next one back.
// Throughput is one beat at a time, set by the table scan and the bit-serial divider.
// Synchronous reset clears control state only; table entries are undefined until loaded.
module thermistor_table_interpolator #(
  parameter int unsigned TABLE_ENTRIES = tti_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned SAMPLE_BITS   = tti_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned TABLE_BITS    = tti_pkg::TABLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [tti_pkg::OP_W-1:0]              op,
  input  logic [tti_pkg::INDEX_W-1:0]           entry_index,
  input  logic signed [tti_pkg::ENTRY_W-1:0]    entry_raw,
  input  logic signed [tti_pkg::ENTRY_W-1:0]    entry_temp,
  input  logic [tti_pkg::SAMPLE_W-1:0]          sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [tti_pkg::TEMP_Q8_W-1:0]  temperature_q8,
  output logic [tti_pkg::SEG_W-1:0]             segment,
  output logic                                  beyond_table
);

  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = IW + 1;
  localparam int unsigned SH_R = (SAMPLE_BITS > TABLE_BITS) ? SAMPLE_BITS - TABLE_BITS : 0;
  localparam int unsigned SH_L = (SAMPLE_BITS > TABLE_BITS) ? 0 : TABLE_BITS - SAMPLE_BITS;
  localparam int unsigned EW = tti_pkg::ENTRY_W;
  localparam int unsigned SUM_W = tti_pkg::SUM_W;
  localparam int unsigned NUM_W = tti_pkg::NUM_W;
  localparam logic [31:0] ENTRIES32 = 32'(TABLE_ENTRIES);
  localparam logic [CW-1:0] ENTRIES_C = CW'(TABLE_ENTRIES);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);
  localparam logic [tti_pkg::STEP_W-1:0] LAST_STEP = tti_pkg::STEP_W'(NUM_W - 1);
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(tti_pkg::Q8_MAX);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(tti_pkg::Q8_MIN);

  tti_pkg::state_t state;

  // Table memory: raw value in the upper half, temperature in the lower half.
  logic [2*EW-1:0] table_mem [TABLE_ENTRIES];
  logic [2*EW-1:0] rd_data;
  logic [IW-1:0]   rd_addr;
  logic [IW-1:0]   wr_addr;
  logic            wr_en;
  logic [IW+tti_pkg::INDEX_W-1:0] idx_wide;

  // Scan and datapath registers.
  logic [CW-1:0]        rd_cnt;
  logic                 rd_vld;
  logic [IW-1:0]        rd_num;
  logic [tti_pkg::ALIGN_W-1:0] s_al;
  logic signed [EW-1:0] low_r, low_t, high_r, high_t;
  logic [tti_pkg::SEG_W-1:0] seg;
  logic                 beyond;
  logic signed [tti_pkg::PROD_W-1:0] prod;
  logic signed [tti_pkg::DT_W-1:0]   dr;
  logic [NUM_W-1:0]     dvd;
  logic [EW-1:0]        rem;
  logic [EW-1:0]        dsr;
  logic                 q_neg;
  logic [tti_pkg::STEP_W-1:0] step;
  logic signed [tti_pkg::TEMP_Q8_W-1:0] res;

  // Combinational helpers.
  logic                 in_acc;
  logic [31:0]          aligned_w;
  logic signed [EW-1:0] scan_raw, scan_temp;
  logic                 scan_hit;
  logic [31:0]          rd_num32;
  logic signed [tti_pkg::DS_W-1:0] diff_s;
  logic signed [tti_pkg::DT_W-1:0] diff_t;
  logic signed [tti_pkg::DT_W-1:0] diff_r;
  logic signed [NUM_W-1:0] num_sc;
  logic [NUM_W-1:0]     num_mag;
  logic [tti_pkg::DT_W-1:0] dr_mag;
  logic [EW:0]          trial;
  logic                 trial_ge;
  logic signed [SUM_W-1:0] q_signed;
  logic signed [SUM_W-1:0] base_sc;
  logic signed [SUM_W-1:0] sum;
  logic                 out_free;

  assign in_ready  = (state == tti_pkg::S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  assign idx_wide  = {{IW{1'b0}}, entry_index};
  assign wr_addr   = idx_wide[IW-1:0];
  assign wr_en     = in_acc && (op == tti_pkg::OP_LOAD) && (32'(entry_index) < ENTRIES32);
  assign rd_addr   = (rd_cnt < ENTRIES_C) ? rd_cnt[IW-1:0] : '0;

  assign aligned_w = (32'(sample) >> SH_R) << SH_L;

  assign scan_raw  = rd_data[2*EW-1:EW];
  assign scan_temp = rd_data[EW-1:0];
  assign scan_hit  = $signed({scan_raw[EW-1], scan_raw}) > $signed({1'b0, s_al});
  assign rd_num32  = 32'(rd_num);

  assign diff_s = $signed({2'b00, s_al}) - $signed({{2{low_r[EW-1]}}, low_r});
  assign diff_t = $signed({high_t[EW-1], high_t}) - $signed({low_t[EW-1], low_t});
  assign diff_r = $signed({high_r[EW-1], high_r}) - $signed({low_r[EW-1], low_r});

  assign num_sc  = {prod, {tti_pkg::FRAC_BITS{1'b0}}};
  assign num_mag = prod[tti_pkg::PROD_W-1] ? NUM_W'(-num_sc) : NUM_W'(num_sc);
  assign dr_mag  = dr[tti_pkg::DT_W-1] ? tti_pkg::DT_W'(-dr) : tti_pkg::DT_W'(dr);

  // Restoring division, one quotient bit per cycle.
  assign trial    = {rem, dvd[NUM_W-1]};
  assign trial_ge = trial >= {1'b0, dsr};

  assign q_signed = q_neg ? -$signed({1'b0, dvd}) : $signed({1'b0, dvd});
  assign base_sc  = {{(SUM_W - EW - tti_pkg::FRAC_BITS){low_t[EW-1]}}, low_t,
                     {tti_pkg::FRAC_BITS{1'b0}}};
  assign sum      = base_sc + q_signed;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= {entry_raw, entry_temp};
    end
    rd_data <= table_mem[rd_addr];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tti_pkg::S_IDLE;
      out_valid <= 1'b0;
      rd_vld    <= 1'b0;
    end else begin
      // In the output state a taken beat is replaced by the next one below.
      if (out_valid && out_ready && state != tti_pkg::S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        tti_pkg::S_IDLE: begin
          rd_vld <= 1'b0;
          if (in_acc && op == tti_pkg::OP_CONVERT) begin
            state <= tti_pkg::S_SCAN;
          end
        end
        tti_pkg::S_SCAN: begin
          rd_vld <= (rd_cnt < ENTRIES_C);
          if (rd_vld && rd_num != '0) begin
            if (scan_hit) begin
              state <= tti_pkg::S_MUL;
            end else if (rd_num == LAST_IDX) begin
              state <= tti_pkg::S_SUM;
            end
          end
        end
        tti_pkg::S_MUL:  state <= tti_pkg::S_PREP;
        tti_pkg::S_PREP: state <= (dr == '0) ? tti_pkg::S_SUM : tti_pkg::S_DIV;
        tti_pkg::S_DIV: begin
          if (step == LAST_STEP) begin
            state <= tti_pkg::S_SUM;
          end
        end
        tti_pkg::S_SUM:  state <= tti_pkg::S_DONE;
        tti_pkg::S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= tti_pkg::S_IDLE;
          end
        end
        default: state <= tti_pkg::S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      tti_pkg::S_IDLE: begin
        rd_cnt <= '0;
        s_al   <= aligned_w[tti_pkg::ALIGN_W-1:0];
      end
      tti_pkg::S_SCAN: begin
        if (rd_cnt < ENTRIES_C) begin
          rd_num <= rd_cnt[IW-1:0];
          rd_cnt <= rd_cnt + CW'(1);
        end
        if (rd_vld) begin
          if (rd_num == '0) begin
            low_r <= scan_raw;
            low_t <= scan_temp;
          end else if (scan_hit) begin
            high_r <= scan_raw;
            high_t <= scan_temp;
            seg    <= rd_num32[tti_pkg::SEG_W-1:0];
            beyond <= 1'b0;
          end else begin
            low_r <= scan_raw;
            low_t <= scan_temp;
            // The last entry's temperature is given unchanged past the table end.
            if (rd_num == LAST_IDX) begin
              seg    <= ENTRIES32[tti_pkg::SEG_W-1:0];
              beyond <= 1'b1;
              dvd    <= '0;
              q_neg  <= 1'b0;
            end
          end
        end
      end
      tti_pkg::S_MUL: begin
        prod <= diff_s * diff_t;
        dr   <= diff_r;
      end
      tti_pkg::S_PREP: begin
        rem  <= '0;
        step <= '0;
        dsr  <= dr_mag[EW-1:0];
        if (dr == '0) begin
          dvd   <= '0;
          q_neg <= 1'b0;
        end else begin
          dvd   <= num_mag;
          q_neg <= prod[tti_pkg::PROD_W-1] ^ dr[tti_pkg::DT_W-1];
        end
      end
      tti_pkg::S_DIV: begin
        step <= step + tti_pkg::STEP_W'(1);
        if (trial_ge) begin
          rem <= EW'(trial - {1'b0, dsr});
          dvd <= {dvd[NUM_W-2:0], 1'b1};
        end else begin
          rem <= trial[EW-1:0];
          dvd <= {dvd[NUM_W-2:0], 1'b0};
        end
      end
      tti_pkg::S_SUM: begin
        if (sum > SAT_HI) begin
          res <= SAT_HI[tti_pkg::TEMP_Q8_W-1:0];
        end else if (sum < SAT_LO) begin
          res <= SAT_LO[tti_pkg::TEMP_Q8_W-1:0];
        end else begin
          res <= sum[tti_pkg::TEMP_Q8_W-1:0];
        end
      end
      tti_pkg::S_DONE: begin
        if (out_free) begin
          temperature_q8 <= res;
          segment        <= seg;
          beyond_table   <= beyond;
        end
      end
      default: begin
        rd_cnt <= '0;
      end
    endcase
  end

endmodule

@@ tb/sv/tb_thermistor_table_interpolator.sv @@
// Self-checking bench for the thermistor table interpolator: loads tables, converts samples
// and compares every temperature result with an in-bench interpolation of the same table.
// Depends on tti_pkg and the thermistor_table_interpolator top level only.
`timescale 1ns / 100ps

module tb_thermistor_table_interpolator;

  localparam int TABLE_N  = tti_pkg::TABLE_ENTRIES_DEF;
  localparam int SAMPLE_N = tti_pkg::SAMPLE_BITS_DEF;
  localparam int TABLE_B  = tti_pkg::TABLE_BITS_DEF;

  typedef struct packed {
    logic signed [tti_pkg::TEMP_Q8_W-1:0] temp_q8;
    logic [tti_pkg::SEG_W-1:0]            seg;
    logic                                 beyond;
  } conversion_t;

  // Mirrors the lookup table and holds the temperatures still owed by the block.
  class conversion_ledger;
    logic signed [tti_pkg::ENTRY_W-1:0] raw_tab [TABLE_N];
    logic signed [tti_pkg::ENTRY_W-1:0] temp_tab[TABLE_N];
    conversion_t                        pending[$];
    int                                 mismatches;

    function new();
      mismatches = 0;
      for (int k = 0; k < TABLE_N; k++) begin
        raw_tab[k]  = '0;
        temp_tab[k] = '0;
      end
    endfunction

    function conversion_t interpolate_sample(logic [tti_pkg::SAMPLE_W-1:0] smp);
      longint      s, lo_r, lo_t, hi_r, hi_t, quo, t;
      bit          found;
      conversion_t r;
      if (SAMPLE_N > TABLE_B) s = longint'(smp) >> (SAMPLE_N - TABLE_B);
      else s = (longint'(smp) << (TABLE_B - SAMPLE_N)) & 64'hFFFF;
      lo_r  = raw_tab[0];
      lo_t  = temp_tab[0];
      hi_t  = 0;
      t     = 0;
      found = 1'b0;
      r.seg    = TABLE_N[tti_pkg::SEG_W-1:0];
      r.beyond = 1'b1;
      for (int i = 1; i < TABLE_N && !found; i++) begin
        hi_r = raw_tab[i];
        hi_t = temp_tab[i];
        if (hi_r > s) begin
          // A flat segment gives the lower entry's temperature unchanged.
          quo = 0;
          if (hi_r != lo_r) quo = ((s - lo_r) * (hi_t - lo_t) * 256) / (hi_r - lo_r);
          t        = lo_t * 256 + quo;
          r.seg    = i[tti_pkg::SEG_W-1:0];
          r.beyond = 1'b0;
          found    = 1'b1;
        end else begin
          lo_r = hi_r;
          lo_t = hi_t;
        end
      end
      if (!found) t = hi_t * 256;
      if (t > tti_pkg::Q8_MAX) t = tti_pkg::Q8_MAX;
      if (t < tti_pkg::Q8_MIN) t = tti_pkg::Q8_MIN;
      r.temp_q8 = t[tti_pkg::TEMP_Q8_W-1:0];
      return r;
    endfunction

    function void record_beat(logic [tti_pkg::OP_W-1:0] o,
                              logic [tti_pkg::INDEX_W-1:0] idx,
                              logic signed [tti_pkg::ENTRY_W-1:0] raw,
                              logic signed [tti_pkg::ENTRY_W-1:0] tmp,
                              logic [tti_pkg::SAMPLE_W-1:0] smp);
      if (o == tti_pkg::OP_LOAD) begin
        if (idx < TABLE_N) begin
          raw_tab[idx]  = raw;
          temp_tab[idx] = tmp;
        end
      end else begin
        pending.push_back(interpolate_sample(smp));
      end
    endfunction

    function void compare_conversion(logic signed [tti_pkg::TEMP_Q8_W-1:0] t,
                                     logic [tti_pkg::SEG_W-1:0] sg, logic bt);
      conversion_t want;
      if (pending.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: result beat with nothing outstanding: temp %0d seg %0d beyond %0b",
                   $time, t, sg, bt);
        mismatches++;
      end else begin
        want = pending.pop_front();
        if (t !== want.temp_q8 || sg !== want.seg || bt !== want.beyond) begin
          if (mismatches < 10)
            $display("%0t: mismatch: temp %0d/%0d seg %0d/%0d beyond %0b/%0b (exp/got)",
                     $time, want.temp_q8, t, want.seg, sg, want.beyond, bt);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic                                 clk;
  logic                                 rst;
  logic                                 in_valid;
  logic                                 in_ready;
  logic [tti_pkg::OP_W-1:0]             op;
  logic [tti_pkg::INDEX_W-1:0]          entry_index;
  logic signed [tti_pkg::ENTRY_W-1:0]   entry_raw;
  logic signed [tti_pkg::ENTRY_W-1:0]   entry_temp;
  logic [tti_pkg::SAMPLE_W-1:0]         sample;
  logic                                 out_valid;
  logic                                 out_ready;
  logic signed [tti_pkg::TEMP_Q8_W-1:0] temperature_q8;
  logic [tti_pkg::SEG_W-1:0]            segment;
  logic                                 beyond_table;

  conversion_ledger ledger = new();
  int               beats_accepted = 0;
  bit               in_calm = 1'b0;
  bit               out_calm = 1'b0;

  thermistor_table_interpolator #(
    .TABLE_ENTRIES(TABLE_N),
    .SAMPLE_BITS  (SAMPLE_N),
    .TABLE_BITS   (TABLE_B)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .entry_index   (entry_index),
    .entry_raw     (entry_raw),
    .entry_temp    (entry_temp),
    .sample        (sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .temperature_q8(temperature_q8),
    .segment       (segment),
    .beyond_table  (beyond_table)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Offers one beat after a random pause; valid stays high when there is no pause.
  task automatic send_beat(input logic [tti_pkg::OP_W-1:0] o, input int idx, input int raw,
                           input int tmp, input int smp);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    op          <= o;
    entry_index <= idx[tti_pkg::INDEX_W-1:0];
    entry_raw   <= raw[tti_pkg::ENTRY_W-1:0];
    entry_temp  <= tmp[tti_pkg::ENTRY_W-1:0];
    sample      <= smp[tti_pkg::SAMPLE_W-1:0];
    do @(posedge clk); while (!in_ready);
    ledger.record_beat(o, idx[tti_pkg::INDEX_W-1:0], raw[tti_pkg::ENTRY_W-1:0],
                       tmp[tti_pkg::ENTRY_W-1:0], smp[tti_pkg::SAMPLE_W-1:0]);
    beats_accepted++;
  endtask

  function automatic int pick_temp();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return -32768;
    if (r == 1) return 32767;
    return $urandom_range(0, 65535);
  endfunction

  // Samples mostly land close to a table breakpoint so that every segment is visited.
  function automatic int pick_sample();
    int r, v;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return 4095;
    if (r <= 3) return $urandom_range(0, 4095);
    v = int'(ledger.raw_tab[$urandom_range(0, TABLE_N - 1)]) + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v;
  endfunction

  // A whole table is loaded first, so no conversion can read an unloaded entry.
  task automatic random_round();
    int kind, base, span, raw, n;
    in_calm = ($urandom_range(0, 3) == 0);
    kind = $urandom_range(0, 5);
    base = int'($urandom_range(0, 800)) - 400;
    span = $urandom_range(1, 300);
    for (int k = 0; k < TABLE_N; k++) begin
      if (kind == 0) begin
        raw = $urandom_range(0, 65535);
      end else begin
        raw  = base;
        base = base + int'($urandom_range(0, span));
      end
      send_beat(tti_pkg::OP_LOAD, k, raw, pick_temp(), $urandom_range(0, 4095));
    end
    n = $urandom_range(15, 40);
    repeat (n) begin
      if ($urandom_range(0, 7) == 0)
        send_beat(tti_pkg::OP_LOAD, $urandom_range(0, 31), $urandom_range(0, 65535),
                  pick_temp(), $urandom_range(0, 4095));
      else
        send_beat(tti_pkg::OP_CONVERT, $urandom_range(0, 31), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), pick_sample());
    end
  endtask

  initial begin
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    op          <= tti_pkg::OP_LOAD;
    entry_index <= '0;
    entry_raw   <= '0;
    entry_temp  <= '0;
    sample      <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part: only entries 0 and 1 are loaded, and entry 1 always lies above the
    // sample. Covers extrapolation below entry 0, both saturation limits, a flat segment
    // and truncation of a negative quotient.
    send_beat(tti_pkg::OP_LOAD, 0, 100, -32768, 0);
    send_beat(tti_pkg::OP_LOAD, 1, 32767, 32767, 4095);
    send_beat(tti_pkg::OP_CONVERT, 0, 0, 0, 0);
    send_beat(tti_pkg::OP_CONVERT, 0, 0, 0, 100);
    send_beat(tti_pkg::OP_CONVERT, 31, 65535, 65535, 4095);
    send_beat(tti_pkg::OP_LOAD, 0, 4095, -32768, 0);
    send_beat(tti_pkg::OP_LOAD, 1, 4096, 32767, 0);
    send_beat(tti_pkg::OP_CONVERT, 0, 0, 0, 0);
    send_beat(tti_pkg::OP_LOAD, 0, 4095, 32767, 0);
    send_beat(tti_pkg::OP_LOAD, 1, 4096, -32768, 0);
    send_beat(tti_pkg::OP_CONVERT, 0, 0, 0, 0);
    send_beat(tti_pkg::OP_LOAD, 0, -32768, 32767, 0);
    send_beat(tti_pkg::OP_LOAD, 1, 32767, -32768, 0);
    send_beat(tti_pkg::OP_CONVERT, 0, 0, 0, 4095);
    send_beat(tti_pkg::OP_LOAD, 0, 3000, 1234, 0);
    send_beat(tti_pkg::OP_LOAD, 1, 3000 + 65536, -5, 0);
    send_beat(tti_pkg::OP_LOAD, 1, 3000, -5, 0);
    send_beat(tti_pkg::OP_CONVERT, 0, 0, 0, 10);
    send_beat(tti_pkg::OP_LOAD, 0, 0, 0, 0);
    send_beat(tti_pkg::OP_LOAD, 1, 3, -1, 0);
    send_beat(tti_pkg::OP_CONVERT, 0, 0, 0, 1);
    send_beat(tti_pkg::OP_LOAD, 1, 3, 1, 0);
    send_beat(tti_pkg::OP_CONVERT, 0, 0, 0, 1);

    while (beats_accepted < 1200) random_round();
    in_valid <= 1'b0;

    while (ledger.pending.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (ledger.mismatches == 0 && ledger.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Result side: a random stall before every result beat, with calm stretches now and then.
  initial begin
    int gap;
    out_ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      gap = out_calm ? 0 : $urandom_range(0, 7);
      if ($urandom_range(0, 24) == 0) out_calm = !out_calm;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      ledger.compare_conversion(temperature_q8, segment, beyond_table);
    end
  end

  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/tti_pkg.sv
rtl/core/thermistor_table_interpolator.sv
tb/sv/tb_thermistor_table_interpolator.sv
